// File: rtl/core/crc16_byte_stream_assert.svh
// ---------------------------------------------------------------------------
// crc16 byte stream assertion macros
// shared concurrent assertion forms for the crc16 byte stream block
// ---------------------------------------------------------------------------
`ifndef CRC16_BYTE_STREAM_ASSERT_SVH
`define CRC16_BYTE_STREAM_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define CRCBS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is high
`define CRCBS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/crcbs_pkg.sv
// ---------------------------------------------------------------------------
// crcbs_pkg
// types and constants shared by the crc16 byte stream modules
// ---------------------------------------------------------------------------
package crcbs_pkg;

   localparam int CRC_W  = 16;
   localparam int BYTE_W = 8;

   typedef logic [CRC_W-1:0]  crc_type;
   typedef logic [BYTE_W-1:0] byte_type;

   // remainder start value and polynomial after reset
   localparam crc_type CRC_INIT   = 16'hFFFF;
   localparam crc_type POLY_RESET = 16'h1021;

   // one message byte with its framing flags
   typedef struct packed {
      byte_type data_byte;
      logic     first_byte;
      logic     last_byte;
   } item_type;

endpackage

// File: rtl/core/crcbs_fold.sv
// ---------------------------------------------------------------------------
// crcbs_fold
// folds one byte into a 16-bit remainder, msb first, eight shift/xor steps
// ---------------------------------------------------------------------------
module crcbs_fold
   import crcbs_pkg::*;
(
   input  crc_type  rem_in,
   input  byte_type data_byte,
   input  crc_type  polynomial,
   output crc_type  rem_out
);

   // byte goes into the top of the remainder, then one step per bit
   always_comb begin
      crc_type r;
      r = rem_in ^ {data_byte, {(CRC_W-BYTE_W){1'b0}}};
      for (int k = 0; k < BYTE_W; k++) begin
         if (r[CRC_W-1]) begin
            r = {r[CRC_W-2:0], 1'b0} ^ polynomial;
         end else begin
            r = {r[CRC_W-2:0], 1'b0};
         end
      end
      rem_out = r;
   end

endmodule

// File: rtl/core/crc16_byte_stream.sv
// ---------------------------------------------------------------------------
// crc16_byte_stream
// crc16 over a byte stream, msb first, start value 0xffff, swapped result
// ---------------------------------------------------------------------------
// The block takes one message byte per clock while the input does not stall,
// and sustains that rate for any message length. A byte is captured in an
// input register; from there the eight-step fold runs into the remainder
// register, and on the last byte the finished remainder, bytes swapped, goes
// into the result register, which drives rsp_valid. The clock-rate limit is
// the remainder feedback path through the eight dependent shift/xor steps.
// first_byte restarts the remainder at 0xffff, and after a last byte it
// restarts on its own. The input stalls only while a finished result waits
// in the result register and the next byte held in the input register is
// also a last byte.
module crc16_byte_stream
   import crcbs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   // byte input
   input  logic     req_valid,
   output logic     req_stall,
   input  byte_type req_data_byte,
   input  logic     req_first_byte,
   input  logic     req_last_byte,
   // crc result
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output crc_type  rsp_crc_value,
   // polynomial register
   input  logic     csr_wr_en,
   input  crc_type  csr_wr_data
);

`include "crc16_byte_stream_assert.svh"

   logic     in_valid_ff, in_valid_in;
   item_type in_item_ff,  in_item_in;
   crc_type  remainder_ff, remainder_in;
   crc_type  poly_ff,      poly_in;
   logic     out_valid_ff, out_valid_in;
   crc_type  out_crc_ff,   out_crc_in;

   logic     req_xfer;
   logic     advance;
   crc_type  fold_start;
   crc_type  fold_result;

   // input stage moves on unless its last byte meets a blocked result slot
   assign advance   = in_valid_ff &&
                      (!in_item_ff.last_byte || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
         in_item_in  = '{data_byte:  req_data_byte,
                         first_byte: req_first_byte,
                         last_byte:  req_last_byte};
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // fold the held byte into the running remainder
   assign fold_start = in_item_ff.first_byte ? CRC_INIT : remainder_ff;

   crcbs_fold u_fold (
      .rem_in     (fold_start),
      .data_byte  (in_item_ff.data_byte),
      .polynomial (poly_ff),
      .rem_out    (fold_result)
   );

   // remainder restarts after a last byte
   always_comb begin
      remainder_in = remainder_ff;
      if (advance) begin
         remainder_in = in_item_ff.last_byte ? CRC_INIT : fold_result;
      end
   end

   // polynomial register
   assign poly_in = csr_wr_en ? csr_wr_data : poly_ff;

   // result register, bytes swapped
   always_comb begin
      out_valid_in = out_valid_ff;
      out_crc_in   = out_crc_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (advance && in_item_ff.last_byte) begin
         out_valid_in = 1'b1;
         out_crc_in   = {fold_result[BYTE_W-1:0], fold_result[CRC_W-1:BYTE_W]};
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         remainder_ff <= CRC_INIT;
         poly_ff      <= POLY_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         remainder_ff <= remainder_in;
         poly_ff      <= poly_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_crc_ff <= out_crc_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_crc_value = out_crc_ff;

   // checks
   `CRCBS_ASSERT_NEXT(a_last_gives_result, clock, reset,
      advance && in_item_ff.last_byte, out_valid_ff, "last byte produced no result")
   `CRCBS_ASSERT_NEXT(a_restart_after_last, clock, reset,
      advance && in_item_ff.last_byte, remainder_ff == CRC_INIT,
      "remainder not restarted after last byte")
   `CRCBS_ASSERT_SAME(a_stall_only_on_blocked_last, clock, reset,
      req_stall, in_valid_ff && in_item_ff.last_byte && out_valid_ff && rsp_stall,
      "input stalled without a blocked result")
   `CRCBS_ASSERT_NEXT(a_remainder_holds_when_idle, clock, reset,
      !advance, $stable(remainder_ff), "remainder changed without a byte")

endmodule
